// ===== rtl/hbe_pkg.sv =====
// ----------------------------------------------------------------------------
// hbe_pkg
// Shared types and constants of the integrated hat basis evaluator.
// ----------------------------------------------------------------------------
package hbe_pkg;

    localparam int FRAC_BITS = 16;
    localparam int VAL_W     = 18;
    localparam int IDX_W     = 6;
    localparam int DVD_W     = 40;
    localparam int DVS_W     = 20;
    localparam int PADDR_W   = 3;

    localparam logic [IDX_W-1:0]   LAST_KNOT_RST  = 6'd50;
    localparam logic [PADDR_W-1:0] ADDR_LAST_KNOT = 3'd0;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH0,
        ST_FETCH1,
        ST_FETCH2,
        ST_PREP,
        ST_MUL0,
        ST_MUL1,
        ST_DIVGO,
        ST_DWAIT,
        ST_Q0,
        ST_PSI,
        ST_SCALE,
        ST_SAT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic             valid;
        logic [DVS_W-1:0] rem;
        logic [DVD_W-1:0] dvd;
        logic [DVD_W-1:0] quo;
        logic [DVS_W-1:0] dvs;
    } div_stage_t;

endpackage

// ===== rtl/hbe_ram.sv =====
// ----------------------------------------------------------------------------
// hbe_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module hbe_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/hbe_div_cell.sv =====
// ----------------------------------------------------------------------------
// hbe_div_cell
// One restoring-division step: one quotient bit, passed on to the next cell.
// ----------------------------------------------------------------------------
module hbe_div_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  hbe_pkg::div_stage_t stage_in,
    output hbe_pkg::div_stage_t stage_out
);

    hbe_pkg::div_stage_t         stage_reg;
    hbe_pkg::div_stage_t         stage_next;
    logic [hbe_pkg::DVS_W:0]     rem_sh;
    logic [hbe_pkg::DVS_W:0]     diff;
    logic                        ge;

    always_comb
    begin
        rem_sh = {stage_in.rem, stage_in.dvd[hbe_pkg::DVD_W-1]};
        diff   = rem_sh - {1'b0, stage_in.dvs};
        ge     = rem_sh >= {1'b0, stage_in.dvs};
        stage_next.valid = stage_in.valid;
        stage_next.rem   = ge ? diff[hbe_pkg::DVS_W-1:0] : rem_sh[hbe_pkg::DVS_W-1:0];
        stage_next.dvd   = {stage_in.dvd[hbe_pkg::DVD_W-2:0], 1'b0};
        stage_next.quo   = {stage_in.quo[hbe_pkg::DVD_W-2:0], ge};
        stage_next.dvs   = stage_in.dvs;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg.valid <= 1'b0;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

// ===== rtl/hbe_div_chain.sv =====
// ----------------------------------------------------------------------------
// hbe_div_chain
// Unsigned divider built as a row of division cells, one bit per cell.
// ----------------------------------------------------------------------------
module hbe_div_chain (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [hbe_pkg::DVD_W-1:0] dividend,
    input  logic [hbe_pkg::DVS_W-1:0] divisor,
    output logic                      done,
    output logic [hbe_pkg::DVD_W-1:0] quotient
);

    hbe_pkg::div_stage_t stg [hbe_pkg::DVD_W+1];

    // valid, rem, dvd, quo, dvs
    assign stg[0] = {start, {hbe_pkg::DVS_W{1'b0}}, dividend, {hbe_pkg::DVD_W{1'b0}}, divisor};

    for (genvar i = 0; i < hbe_pkg::DVD_W; i++)
    begin : g_cell
        hbe_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .stage_in (stg[i]),
            .stage_out(stg[i+1])
        );
    end

    assign done     = stg[hbe_pkg::DVD_W].valid;
    assign quotient = stg[hbe_pkg::DVD_W].quo;

endmodule

// ===== rtl/integrated_hat_basis_eval_core.sv =====
// Load word: accepted while idle, written to the knot table.
// Evaluate word: knots are fetched, then each basis value runs PREP, the 40-cell
// divider chain and SAT, skipping it when no division is needed; plus stalls.
// L+1 values per word, one word in flight; the next is taken after the last value.
// Reset clears control state and sets last_knot_index to 50; the knot table is
// not cleared.
// ----------------------------------------------------------------------------
// integrated_hat_basis_eval_core
// Integrated linear B-spline basis evaluator, Q1.16, with knot table.
// ----------------------------------------------------------------------------
module integrated_hat_basis_eval_core #(
    parameter int MAX_KNOTS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // knot_index[5:0], value[23:6]
    input  logic [0:0]  s_tuser,   // opcode[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // basis_index[5:0], basis_value[23:6]
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW       = $clog2(MAX_KNOTS);
    localparam int RD_W     = (AW > 7) ? AW : 7;
    localparam int LAST_CAP = (MAX_KNOTS - 1 < 63) ? MAX_KNOTS - 1 : 63;

    localparam logic signed [18:0] ONE_19  = 19'sd65536;
    localparam logic signed [17:0] NONE_18 = -18'sd65536;

    function automatic logic signed [18:0] half19(input logic signed [18:0] v);
        logic signed [18:0] b;
        b = v + $signed({18'b0, v[18]});
        return b >>> 1;
    endfunction

    hbe_pkg::state_t state_reg, state_next;

    logic [5:0]         last_knot_reg;
    logic [5:0]         eff_last;
    logic signed [17:0] x_reg, x_next;
    logic [5:0]         l_reg, l_next;
    logic signed [17:0] prev_reg, prev_next, cur_reg, cur_next, nxt_reg, nxt_next;
    logic signed [18:0] d_reg, d_next;
    logic signed [19:0] den_reg, den_next;
    logic               branch_b_reg, branch_b_next;
    logic signed [39:0] num_reg, num_next;
    logic signed [36:0] p1_reg, p1_next;
    logic signed [35:0] p2_reg, p2_next;
    logic               neg_reg, neg_next;
    logic [39:0]        q_reg, q_next;
    logic [16:0]        psi_reg, psi_next;
    logic signed [23:0] res_reg, res_next;
    logic [5:0]         oidx_reg, oidx_next;
    logic [17:0]        oval_reg, oval_next;
    logic               olast_reg, olast_next;

    logic [5:0]         in_knot;
    logic signed [17:0] in_value;
    logic               in_acc;
    logic               is_l0, is_last;
    logic signed [18:0] d_w, e_w, xm_w, u1p_w, xp1_w;
    logic signed [19:0] den0_w;
    logic               x_le_m1, x_lt_u1, x_lt_cur;
    logic signed [39:0] num_w;
    logic [39:0]        num_mag;
    logic [19:0]        den_mag;
    logic [17:0]        qc18;
    logic [16:0]        s17;
    logic [17:0]        pa;
    logic [16:0]        pb;
    logic [34:0]        pprod;
    logic [18:0]        qc19;
    logic signed [23:0] qc24;
    logic signed [17:0] hs;
    logic signed [19:0] opa;
    logic signed [17:0] opb;
    logic signed [37:0] sprod, sprod_b;
    logic signed [21:0] tr22;

    logic               ram_we, ram_re;
    logic [RD_W-1:0]    wr_idx, rd_idx;
    logic [17:0]        ram_rdata;
    logic               div_start, div_done;
    logic [39:0]        div_q;

    assign in_knot  = s_tdata[5:0];
    assign in_value = $signed(s_tdata[23:6]);
    assign in_acc   = s_tvalid && s_tready;
    assign eff_last = (last_knot_reg > 6'(LAST_CAP)) ? 6'(LAST_CAP) : last_knot_reg;
    assign is_l0    = (l_reg == 6'd0);
    assign is_last  = (l_reg == eff_last);

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == hbe_pkg::ADDR_LAST_KNOT) ? {26'b0, last_knot_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_knot_reg <= hbe_pkg::LAST_KNOT_RST;
        end
        else if (psel && penable && pwrite && pready && paddr == hbe_pkg::ADDR_LAST_KNOT)
        begin
            last_knot_reg <= pwdata[5:0];
        end
    end

    // knot table and divider
    assign wr_idx = RD_W'(in_knot);

    hbe_ram #(
        .WIDTH(hbe_pkg::VAL_W),
        .DEPTH(MAX_KNOTS)
    ) u_knots (
        .clk  (clk),
        .we   (ram_we),
        .waddr(wr_idx[AW-1:0]),
        .wdata(s_tdata[23:6]),
        .re   (ram_re),
        .raddr(rd_idx[AW-1:0]),
        .rdata(ram_rdata)
    );

    hbe_div_chain u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(num_mag),
        .divisor (den_mag),
        .done    (div_done),
        .quotient(div_q)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hbe_pkg::ST_IDLE:
            begin
                if (in_acc && s_tuser[0] == hbe_pkg::OP_EVAL)
                begin
                    state_next = hbe_pkg::ST_FETCH0;
                end
            end
            hbe_pkg::ST_FETCH0: state_next = hbe_pkg::ST_FETCH1;
            hbe_pkg::ST_FETCH1: state_next = hbe_pkg::ST_FETCH2;
            hbe_pkg::ST_FETCH2: state_next = hbe_pkg::ST_PREP;
            hbe_pkg::ST_PREP:
            begin
                if (is_l0)
                begin
                    if (x_le_m1 || !x_lt_u1 || den0_w == 20'sd0)
                    begin
                        state_next = hbe_pkg::ST_SAT;
                    end
                    else
                    begin
                        state_next = hbe_pkg::ST_MUL0;
                    end
                end
                else if (x_lt_cur ? (d_w == 19'sd0) : (e_w == 19'sd0))
                begin
                    state_next = hbe_pkg::ST_SAT;
                end
                else
                begin
                    state_next = hbe_pkg::ST_DIVGO;
                end
            end
            hbe_pkg::ST_MUL0:  state_next = hbe_pkg::ST_MUL1;
            hbe_pkg::ST_MUL1:  state_next = hbe_pkg::ST_DIVGO;
            hbe_pkg::ST_DIVGO: state_next = hbe_pkg::ST_DWAIT;
            hbe_pkg::ST_DWAIT:
            begin
                if (div_done)
                begin
                    state_next = is_l0 ? hbe_pkg::ST_Q0 : hbe_pkg::ST_PSI;
                end
            end
            hbe_pkg::ST_Q0:    state_next = hbe_pkg::ST_SAT;
            hbe_pkg::ST_PSI:   state_next = hbe_pkg::ST_SCALE;
            hbe_pkg::ST_SCALE: state_next = hbe_pkg::ST_SAT;
            hbe_pkg::ST_SAT:   state_next = hbe_pkg::ST_OUT;
            hbe_pkg::ST_OUT:
            begin
                if (m_tready)
                begin
                    state_next = is_last ? hbe_pkg::ST_IDLE : hbe_pkg::ST_PREP;
                end
            end
            default: state_next = hbe_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        s_tready  = (state_reg == hbe_pkg::ST_IDLE);
        m_tvalid  = (state_reg == hbe_pkg::ST_OUT);
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        rd_idx    = '0;
        div_start = 1'b0;
        unique case (state_reg)
            hbe_pkg::ST_IDLE:
            begin
                ram_we = in_acc && s_tuser[0] == hbe_pkg::OP_LOAD
                         && 32'(in_knot) < MAX_KNOTS;
            end
            hbe_pkg::ST_FETCH0:
            begin
                ram_re = 1'b1;
            end
            hbe_pkg::ST_FETCH1:
            begin
                ram_re = 1'b1;
                rd_idx = RD_W'(1);
            end
            hbe_pkg::ST_PREP:
            begin
                ram_re = 1'b1;
                rd_idx = RD_W'(l_reg) + RD_W'(2);
            end
            hbe_pkg::ST_DIVGO:
            begin
                div_start = 1'b1;
            end
            default:
            begin
                ram_re = 1'b0;
            end
        endcase
    end

    assign m_tdata = {oval_reg, oidx_reg};
    assign m_tlast = olast_reg;

    // datapath
    always_comb
    begin
        d_w      = {cur_reg[17], cur_reg} - {prev_reg[17], prev_reg};
        e_w      = is_last ? d_w : ({nxt_reg[17], nxt_reg} - {cur_reg[17], cur_reg});
        xm_w     = {x_reg[17], x_reg} - {cur_reg[17], cur_reg};
        u1p_w    = {nxt_reg[17], nxt_reg} + ONE_19;
        xp1_w    = {x_reg[17], x_reg} + ONE_19;
        den0_w   = {u1p_w, 1'b0};
        x_le_m1  = x_reg <= NONE_18;
        x_lt_u1  = x_reg < nxt_reg;
        x_lt_cur = x_reg < cur_reg;

        num_w   = is_l0 ? ((40'(p1_reg) <<< 1) + 40'sh01_0000_0000 - 40'(p2_reg)) : num_reg;
        num_mag = num_w[39] ? 40'(-num_w) : 40'(num_w);
        den_mag = den_reg[19] ? 20'(-den_reg) : 20'(den_reg);

        qc19 = (q_reg > 40'h40000) ? 19'h40000 : q_reg[18:0];
        qc24 = $signed({5'b0, qc19});

        qc18  = (q_reg > 40'h20000) ? 18'h20000 : q_reg[17:0];
        s17   = 17'(18'h10000 - qc18);
        pa    = neg_reg ? {1'b0, s17} : 18'(18'h20000 - qc18);
        pb    = neg_reg ? s17 : qc18[16:0];
        pprod = 35'(pa) * 35'(pb);

        hs      = $signed({1'b0, psi_reg}) - 18'sd32768;
        opa     = branch_b_reg ? den_reg : {d_reg[18], d_reg};
        opb     = branch_b_reg ? hs : $signed({1'b0, psi_reg});
        sprod   = 38'(opa) * 38'(opb);
        sprod_b = sprod + (sprod[37] ? 38'sd65535 : 38'sd0);
        tr22    = sprod_b[37:16];

        x_next        = x_reg;
        l_next        = l_reg;
        prev_next     = prev_reg;
        cur_next      = cur_reg;
        nxt_next      = nxt_reg;
        d_next        = d_reg;
        den_next      = den_reg;
        branch_b_next = branch_b_reg;
        num_next      = num_reg;
        p1_next       = p1_reg;
        p2_next       = p2_reg;
        neg_next      = neg_reg;
        q_next        = q_reg;
        psi_next      = psi_reg;
        res_next      = res_reg;
        oidx_next     = oidx_reg;
        oval_next     = oval_reg;
        olast_next    = olast_reg;

        unique case (state_reg)
            hbe_pkg::ST_IDLE:
            begin
                x_next = in_value;
                l_next = '0;
            end
            hbe_pkg::ST_FETCH1:
            begin
                cur_next = $signed(ram_rdata);
            end
            hbe_pkg::ST_FETCH2:
            begin
                nxt_next = $signed(ram_rdata);
            end
            hbe_pkg::ST_PREP:
            begin
                d_next        = d_w;
                branch_b_next = !x_lt_cur;
                num_next      = 40'(xm_w) <<< 16;
                if (is_l0)
                begin
                    den_next = den0_w;
                    if (x_le_m1 || den0_w == 20'sd0)
                    begin
                        res_next = '0;
                    end
                    else
                    begin
                        res_next = 24'(half19(u1p_w));
                    end
                end
                else if (x_lt_cur)
                begin
                    den_next = {d_w[18], d_w};
                    res_next = '0;
                end
                else
                begin
                    den_next = {e_w[18], e_w};
                    res_next = 24'(half19(d_w));
                end
            end
            hbe_pkg::ST_MUL0:
            begin
                p1_next = 37'(nxt_reg) * 37'(xp1_w);
            end
            hbe_pkg::ST_MUL1:
            begin
                p2_next = 36'(x_reg) * 36'(x_reg);
            end
            hbe_pkg::ST_DIVGO:
            begin
                neg_next = num_w[39] ^ den_reg[19];
            end
            hbe_pkg::ST_DWAIT:
            begin
                q_next = div_q;
            end
            hbe_pkg::ST_Q0:
            begin
                res_next = neg_reg ? -qc24 : qc24;
            end
            hbe_pkg::ST_PSI:
            begin
                if (neg_reg)
                begin
                    psi_next = (qc18 > 18'h10000) ? 17'd0 : pprod[33:17];
                end
                else if (qc18 >= 18'h10000)
                begin
                    psi_next = 17'h10000;
                end
                else
                begin
                    psi_next = 17'd32768 + pprod[33:17];
                end
            end
            hbe_pkg::ST_SCALE:
            begin
                res_next = 24'(tr22) + (branch_b_reg ? 24'(half19(d_reg)) : 24'sd0);
            end
            hbe_pkg::ST_SAT:
            begin
                oidx_next  = l_reg;
                olast_next = is_last;
                if (res_reg > 24'sd131071)
                begin
                    oval_next = 18'h1FFFF;
                end
                else if (res_reg < -24'sd131072)
                begin
                    oval_next = 18'h20000;
                end
                else
                begin
                    oval_next = res_reg[17:0];
                end
            end
            hbe_pkg::ST_OUT:
            begin
                if (m_tready && !is_last)
                begin
                    l_next    = l_reg + 6'd1;
                    prev_next = cur_reg;
                    cur_next  = nxt_reg;
                    nxt_next  = $signed(ram_rdata);
                end
            end
            default:
            begin
                x_next = x_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hbe_pkg::ST_IDLE;
            l_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            l_reg     <= l_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        prev_reg     <= prev_next;
        cur_reg      <= cur_next;
        nxt_reg      <= nxt_next;
        d_reg        <= d_next;
        den_reg      <= den_next;
        branch_b_reg <= branch_b_next;
        num_reg      <= num_next;
        p1_reg       <= p1_next;
        p2_reg       <= p2_next;
        neg_reg      <= neg_next;
        q_reg        <= q_next;
        psi_reg      <= psi_next;
        res_reg      <= res_next;
        oidx_reg     <= oidx_next;
        oval_reg     <= oval_next;
        olast_reg    <= olast_next;
    end

    a_last_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> s_tready)
        else $error("not idle after final basis word");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (oidx_reg == eff_last)))
        else $error("last flag does not match final knot index");

    a_div_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == hbe_pkg::ST_DWAIT)
        else $error("divider result while not waiting for it");

    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> l_reg == $past(l_reg) + 6'd1)
        else $error("basis index did not advance by one");

endmodule

// ===== tb/integrated_hat_basis_eval_core_tb.sv =====
// ----------------------------------------------------------------------------
// integrated_hat_basis_eval_core_tb
// Drives knot loads and evaluate words into the core, predicts every basis
// word from a local model of the knot table and final knot index, and checks
// the output stream word by word under random idling and backpressure.
// ----------------------------------------------------------------------------
module integrated_hat_basis_eval_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ONE      = longint'(1) << hbe_pkg::FRAC_BITS;
    localparam longint VMAX     = 131071;
    localparam longint VMIN     = -131072;
    localparam int     WD_LIMIT = 4000;
    localparam int     HOLD_LEN = 600;

    typedef struct {
        logic [hbe_pkg::IDX_W-1:0]        idx;
        logic signed [hbe_pkg::VAL_W-1:0] val;
        logic                             last;
    } basis_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;    // knot_index[5:0], value[23:6]
    logic [0:0]  s_tuser = '0;    // opcode[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // basis_index[5:0], basis_value[23:6]
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    integrated_hat_basis_eval_core dut (.*);

    always #2 clk = ~clk;

    longint      knot_mdl [64];
    int          last_mdl = 50;
    basis_word_t basis_expq [$];
    int          errors = 0;
    int          idle_cycles = 0;
    bit          no_idle = 1'b0;
    int          hold_req = 0;
    int          hold_seen = 0;
    int          hold_left = 0;

    function automatic longint psi_fx(longint t);
        if (t < -ONE) return 0;
        if (t < 0) return ((t + ONE) * (t + ONE)) / (2 * ONE);
        if (t < ONE) return ONE / 2 + ((2 * ONE - t) * t) / (2 * ONE);
        return ONE;
    endfunction

    function automatic longint basis_val(longint x, int l, int lst);
        longint u1, ul, d, up, e, r, num, den;
        if (l == 0) begin
            u1 = knot_mdl[1];
            if (x <= -ONE) return 0;
            if (x < u1) begin
                den = 2 * (u1 + ONE);
                num = 2 * u1 * (ONE + x) + ONE * ONE - x * x;
                if (den == 0) return 0;
                return num / den;
            end
            return (u1 + ONE) / 2;
        end
        ul = knot_mdl[l];
        d  = ul - knot_mdl[l-1];
        if (x < ul) begin
            if (d == 0) return 0;
            return (d * psi_fx(((x - ul) * ONE) / d)) / ONE;
        end
        up = (l == lst) ? 2 * ul - knot_mdl[l-1] : knot_mdl[l+1];
        e  = up - ul;
        r  = d / 2;
        if (e != 0) r += (e * (psi_fx(((x - ul) * ONE) / e) - ONE / 2)) / ONE;
        return r;
    endfunction

    function automatic void predict_word(logic op, logic [hbe_pkg::IDX_W-1:0] slot,
                                         logic signed [hbe_pkg::VAL_W-1:0] v);
        basis_word_t w;
        longint r;
        if (op == hbe_pkg::OP_LOAD) begin
            knot_mdl[slot] = v;
            return;
        end
        for (int l = 0; l <= last_mdl; l++) begin
            r = basis_val(longint'(v), l, last_mdl);
            if (r > VMAX) r = VMAX;
            if (r < VMIN) r = VMIN;
            w.idx  = l[hbe_pkg::IDX_W-1:0];
            w.val  = r[hbe_pkg::VAL_W-1:0];
            w.last = (l == last_mdl);
            basis_expq.push_back(w);
        end
    endfunction

    task automatic send_word(logic op, logic [hbe_pkg::IDX_W-1:0] slot,
                             logic signed [hbe_pkg::VAL_W-1:0] v);
        if (!no_idle && $urandom_range(99) < 8) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {v, slot};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predict_word(op, slot, v);
    endtask

    task automatic load_knot(int slot, longint v);
        send_word(hbe_pkg::OP_LOAD, slot[hbe_pkg::IDX_W-1:0], v[hbe_pkg::VAL_W-1:0]);
    endtask

    task automatic eval_at(longint x);
        send_word(hbe_pkg::OP_EVAL, '0, x[hbe_pkg::VAL_W-1:0]);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (basis_expq.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_last_knot(int lst);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= hbe_pkg::ADDR_LAST_KNOT;
        pwdata  <= 32'(lst);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        last_mdl = lst;
        @(posedge clk);
    endtask

    // increasing knots with random spacing, occasionally repeated or reversed
    task automatic load_table(int count, longint start, int max_step);
        longint u = start;
        for (int k = 0; k < count; k++) begin
            load_knot(k, u);
            case ($urandom_range(9))
                0:       u = u;
                1:       u = u - $urandom_range(max_step);
                default: u = u + $urandom_range(max_step, 1);
            endcase
            if (u > VMAX) u = VMAX;
            if (u < VMIN) u = VMIN;
        end
    endtask

    task automatic test_directed();
        write_last_knot(2);
        load_knot(0, -ONE); load_knot(1, 0); load_knot(2, ONE / 2); load_knot(3, ONE);
        eval_at(VMIN); eval_at(-ONE); eval_at(-ONE / 2); eval_at(0);
        eval_at(ONE / 4); eval_at(ONE / 2); eval_at(ONE); eval_at(VMAX);
        load_knot(1, -ONE);                     // zero divisor in basis 0
        eval_at(-ONE + 1); eval_at(0);
        load_knot(1, ONE / 2); load_knot(2, ONE / 2); load_knot(3, ONE / 2);
        eval_at(ONE / 4); eval_at(ONE);         // zero spacing both sides
        load_knot(0, VMIN); load_knot(1, VMIN); load_knot(2, VMAX); load_knot(3, VMAX);
        eval_at(0); eval_at(VMAX); eval_at(VMIN + 7);   // saturation
    endtask

    task automatic test_final_index();
        write_last_knot(0);
        load_knot(1, ONE / 3);
        eval_at(0); eval_at(ONE);
        write_last_knot(1);
        load_knot(0, -ONE / 3);
        eval_at(-ONE / 8); eval_at(ONE / 2);
        load_table(64, -ONE - 30000, 4000);
        write_last_knot(63);
        eval_at(0); eval_at(ONE);
        write_last_knot(50);
        eval_at(-ONE / 2);
    endtask

    task automatic test_backpressure();
        write_last_knot(3);
        hold_req++;
        for (int i = 0; i < 6; i++) eval_at($urandom_range(2 * ONE) - ONE);
    endtask

    task automatic test_random(int n);
        int lst;
        longint x;
        for (int ph = 0; ph < 7; ph++) begin
            lst = (ph == 3) ? 63 : $urandom_range(10, 2);
            write_last_knot(lst);
            no_idle = (ph == 2);
            load_table(lst + 2 > 64 ? 64 : lst + 2, longint'($urandom_range(2 * ONE)) - 2 * ONE,
                       $urandom_range(40000, 2000));
            for (int i = 0; i < (lst == 63 ? 4 : n / 7); i++) begin
                case ($urandom_range(9))
                    0, 1: load_knot($urandom_range(63), longint'($urandom_range(262143)) - 131072);
                    2:    eval_at(longint'($urandom_range(262143)) - 131072);
                    default: begin
                        x = knot_mdl[$urandom_range(lst)] + longint'($urandom_range(40000)) - 20000;
                        if (x > VMAX) x = VMAX;
                        if (x < VMIN) x = VMIN;
                        eval_at(x);
                    end
                endcase
            end
        end
        no_idle = 1'b0;
    endtask

    always @(posedge clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= no_idle || ($urandom_range(99) >= 8);
        end
    end

    always @(posedge clk) begin
        basis_word_t w;
        if (rst_n && m_tvalid && m_tready) begin
            if (basis_expq.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected word %h last %b", m_tdata, m_tlast);
            end else begin
                w = basis_expq.pop_front();
                if (m_tdata[5:0] !== w.idx || m_tdata[23:6] !== w.val || m_tlast !== w.last) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp idx %0d val %0d last %b, got idx %0d val %0d last %b",
                                 w.idx, w.val, w.last, m_tdata[5:0],
                                 $signed(m_tdata[23:6]), m_tlast);
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WD_LIMIT) begin
            $display("timeout: no word moved in %0d cycles", WD_LIMIT);
            $display("** integrated_hat_basis_eval_core: FAILED **");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_directed();
        test_final_index();
        test_backpressure();
        test_random(180);
        drain();
        if (basis_expq.size() != 0) errors++;
        if (errors == 0)
            $display("** integrated_hat_basis_eval_core: PASSED **");
        else
            $display("** integrated_hat_basis_eval_core: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/hbe_pkg.sv
rtl/hbe_ram.sv
rtl/hbe_div_cell.sv
rtl/hbe_div_chain.sv
rtl/integrated_hat_basis_eval_core.sv
tb/integrated_hat_basis_eval_core_tb.sv
